// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file lcrf_checker.sv.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge outside reset
`define LCRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent
`define LCRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lcrf_pkg.sv -----
// Shared constants for the line counting receive FIFO.
// No dependencies; used by the top level and its checker.
package lcrf_pkg;

    // default storage depth in bytes
    localparam int DEPTH_DEFAULT = 512;

    // character codes
    localparam logic [7:0] LF_CODE = 8'd10;
    localparam logic [7:0] CR_CODE = 8'd13;

    // request action codes
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

endpackage

// ----- sv/lcrf_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module lcrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/line_counting_receive_fifo.sv -----
// Line counting receive FIFO: byte storage in lcrf_ram plus index and count logic.
// Depends on lcrf_pkg and lcrf_ram.
//
// Usage:
//   Request channel (req_valid / req_stall) carries action and rx_byte. A push
//   stores rx_byte unless it is a carriage return or the FIFO is full; a pop
//   takes the oldest byte. Every request yields exactly one response on the
//   response channel (rsp_valid / rsp_stall) with the flags, fill_level and
//   lines_held after that request.
// Response timing:
//   For a push, or a pop of an empty FIFO, the response is registered and
//   shows the cycle after acceptance.
//   A pop of a stored byte passes through ST_POP_WAIT: the byte RAM has a
//   registered read, and the line count update waits on the byte read. The
//   response is registered from ST_POP_WAIT; no request is taken in that state.
// Reset:
//   Indices, occupancy and line count clear to zero. The byte RAM is not
//   cleared; only written entries are ever read.
// Stall:
//   A response waits in the output register while rsp_stall is high; a new
//   request is taken only when that register is free or being emptied and no pop is waiting.
module line_counting_receive_fifo
    import lcrf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic                           action,
    input  logic [7:0]                     rx_byte,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [7:0]                     read_byte,
    output logic                           was_empty,
    output logic                           byte_stored,
    output logic                           byte_dropped,
    output logic [$clog2(DEPTH+1)-1:0]     fill_level,
    output logic [$clog2(DEPTH+1)-1:0]     lines_held
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic ST_IDLE     = 1'b0;
    localparam logic ST_POP_WAIT = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0] lines_reg, lines_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [7:0]       read_byte_reg, read_byte_next;
    logic             was_empty_reg, was_empty_next;
    logic             stored_reg, stored_next;
    logic             dropped_reg, dropped_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             rsp_load;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             push_ok;
    logic             pop_ok;
    logic [7:0]       ram_rdata;

    // handshake
    assign req_stall = (state_reg == ST_POP_WAIT) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    assign is_full  = (occ_reg == CNT_W'(DEPTH));
    assign is_empty = (occ_reg == '0);
    assign push_ok  = accept && (action == ACT_PUSH) && !is_full && (rx_byte != CR_CODE);
    assign pop_ok   = accept && (action == ACT_POP) && !is_empty;

    // byte storage
    lcrf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push_ok),
        .waddr (wr_idx_reg),
        .wdata (rx_byte),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    // state, index and count update
    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        occ_next    = occ_reg;
        lines_next  = lines_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (push_ok)
                begin
                    wr_idx_next = (wr_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
                    occ_next    = occ_reg + 1'b1;
                    if (rx_byte == LF_CODE)
                    begin
                        lines_next = lines_reg + 1'b1;
                    end
                end
                if (pop_ok)
                begin
                    rd_idx_next = (rd_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
                    occ_next    = occ_reg - 1'b1;
                    state_next  = ST_POP_WAIT;
                end
            end
            ST_POP_WAIT:
            begin
                // read data is back; finish the line count
                if ((ram_rdata == LF_CODE) && (lines_reg != '0))
                begin
                    lines_next = lines_reg - 1'b1;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response build
    always_comb
    begin
        rsp_load       = 1'b0;
        read_byte_next = 8'd0;
        was_empty_next = 1'b0;
        stored_next    = 1'b0;
        dropped_next   = 1'b0;
        fill_next      = occ_next;
        held_next      = lines_next;

        if (state_reg == ST_POP_WAIT)
        begin
            rsp_load       = 1'b1;
            read_byte_next = ram_rdata;
        end
        else if (accept && !pop_ok)
        begin
            rsp_load = 1'b1;
            if (action == ACT_POP)
            begin
                was_empty_next = 1'b1;
            end
            else
            begin
                stored_next  = push_ok;
                dropped_next = is_full;
            end
        end

        rsp_valid_next = (rsp_valid_reg && rsp_stall) || rsp_load;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            occ_reg       <= '0;
            lines_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            occ_reg       <= occ_next;
            lines_reg     <= lines_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            read_byte_reg <= read_byte_next;
            was_empty_reg <= was_empty_next;
            stored_reg    <= stored_next;
            dropped_reg   <= dropped_next;
            fill_reg      <= fill_next;
            held_reg      <= held_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign read_byte    = read_byte_reg;
    assign was_empty    = was_empty_reg;
    assign byte_stored  = stored_reg;
    assign byte_dropped = dropped_reg;
    assign fill_level   = fill_reg;
    assign lines_held   = held_reg;

endmodule

// ----- sv/lcrf_checker.sv -----
// Port level checks for line_counting_receive_fifo, bound to the top level.
// Depends on lcrf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcrf_checker
    import lcrf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_stall,
    input logic                       action,
    input logic [7:0]                 rx_byte,
    input logic                       rsp_valid,
    input logic                       rsp_stall,
    input logic [7:0]                 read_byte,
    input logic                       was_empty,
    input logic                       byte_stored,
    input logic                       byte_dropped,
    input logic [$clog2(DEPTH+1)-1:0] fill_level,
    input logic [$clog2(DEPTH+1)-1:0] lines_held
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                   flags_ok;
    logic                   fill_ok;
    logic                   rsp_held;
    logic [10+2*CNT_W:0]    rsp_word;

    // at most one outcome flag, and an empty pop returns zero
    assign flags_ok = $onehot0({was_empty, byte_stored, byte_dropped})
                      && (!was_empty || (read_byte == 8'd0));

    // a stored byte leaves the FIFO non-empty, a drop means it is full
    assign fill_ok = (!byte_stored || (fill_level != '0))
                     && (!byte_dropped || (fill_level == DEPTH));

    // whole response payload, for the hold check
    assign rsp_held = rsp_valid && rsp_stall;
    assign rsp_word = {read_byte, was_empty, byte_stored, byte_dropped, fill_level, lines_held};

    // occupancy never exceeds the storage
    `LCRF_ASSERT(a_fill_range, !rsp_valid || (fill_level <= DEPTH), "fill_level above depth")

    // every held line feed is a held byte
    `LCRF_ASSERT(a_lines_le_fill, !rsp_valid || (lines_held <= fill_level), "lines_held above fill")

    // outcome flags agree with each other
    `LCRF_ASSERT(a_flags, !rsp_valid || flags_ok, "bad response flags")

    // fill level agrees with the outcome
    `LCRF_ASSERT(a_store_fill, !rsp_valid || fill_ok, "fill inconsistent with outcome")

    // a stalled response holds
    `LCRF_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_word), "rsp changed in stall")

endmodule

bind line_counting_receive_fifo lcrf_checker #(.DEPTH(DEPTH)) u_lcrf_checker (.*);
